/* src/dcs_pkg.sv */
package dcs_pkg;

  localparam int NODE_COUNT_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int SLOT_LIMIT     = 32;

  localparam int DATA_W  = 32;
  localparam int LIM_W   = 31;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 5;
  localparam int LIVE_W  = 6;
  localparam int AGE_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 72;

  localparam logic [AGE_W-1:0] NODE_LIFE = AGE_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_RUN    = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_DROOP_GAIN  = 2'd0,
    REG_SHIFT_GAIN  = 2'd1,
    REG_DROOP_LIMIT = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_WALK_END,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL_D,
    S_MUL_S,
    S_CORR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic walk_en;
  } slot_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/dcs_slots.sv */
module dcs_slots #(
  parameter int SLOTS  = 32,
  parameter int SLOT_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dcs_pkg::slot_ctl_t         ctl,
  input  logic [SLOT_W-1:0]          wr_addr,
  input  logic [dcs_pkg::DATA_W-1:0] wr_data,
  input  logic [SLOT_W-1:0]          rd_addr,
  output logic [dcs_pkg::DATA_W-1:0] rd_data,
  output logic                       rd_live
);
  import dcs_pkg::*;

  logic [DATA_W-1:0] cur_mem [SLOTS];
  logic [AGE_W-1:0]  age_r [SLOTS];
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_live_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      cur_mem[wr_addr] <= wr_data;
    end
    if (ctl.walk_en) begin
      rd_data_r <= cur_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        age_r[i] <= '0;
      end
      rd_live_r <= 1'b0;
    end else begin
      rd_live_r <= ctl.walk_en && (age_r[rd_addr] != '0);
      if (ctl.wr_en) begin
        age_r[wr_addr] <= NODE_LIFE;
      end else if (ctl.walk_en && (age_r[rd_addr] != '0)) begin
        age_r[rd_addr] <= age_r[rd_addr] - AGE_W'(1);
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_live = rd_live_r;

endmodule

/* src/dcs_mul.sv */
module dcs_mul (
  input  logic                                clk,
  input  logic signed [dcs_pkg::DATA_W-1:0]   a,
  input  logic signed [dcs_pkg::DATA_W-1:0]   b,
  output logic signed [2*dcs_pkg::DATA_W-1:0] p
);
  import dcs_pkg::*;

  logic signed [2*DATA_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

/* src/dcs_div.sv */
module dcs_div #(
  parameter int SUM_W = 38,
  parameter int CNT_W = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           dividend,
  input  logic [CNT_W-1:0]                  divisor,
  output dcs_pkg::div_stat_t                stat,
  output logic signed [dcs_pkg::DATA_W-1:0] quotient
);
  import dcs_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic              take;
  logic [SUM_W-1:0]  q_signed;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r <= STEP_W'(SUM_W);
      end else if (step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
        done_r <= (step_r == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      q_r   <= dividend[SUM_W-1] ? -dividend : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step_r != '0) begin
      rem_r <= take ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      q_r   <= {q_r[SUM_W-2:0], take};
    end
  end

  assign q_signed  = neg_r ? -q_r : q_r;
  assign quotient  = q_signed[DATA_W-1:0];
  assign stat.busy = step_r != '0;
  assign stat.done = done_r;

endmodule

/* src/droop_current_sharing.sv */
// Report and no-op words go straight to output. Run words form the droop term,
// then the shift term (one multiplier serves both terms), then the correction.
// Averaging ticks sum the live slots, then divide by the live count (skipped,
// average 0, when no slot is live). Ticks read one slot per cycle, then take
// one quotient bit per cycle. One word at a time: the next is taken in the
// cycle after the result is registered; a waiting result holds it back.
// Synchronous active-low reset clears control, ages, average, count, config.
module droop_current_sharing #(
  parameter int NODE_COUNT = dcs_pkg::NODE_COUNT_DEF,
  parameter int FRAC_BITS  = dcs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dcs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [dcs_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // opcode[1:0], node_index[6:2], current_sample[38:7], voltage_reference[70:39]
  input  logic [dcs_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // corrected_voltage[31:0], average_current[63:32], live_node_count[69:64]
  output logic [dcs_pkg::OUT_W-1:0]   out_tdata
);
  import dcs_pkg::*;

  localparam int SLOTS  = (NODE_COUNT < SLOT_LIMIT) ? NODE_COUNT : SLOT_LIMIT;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SUM_W  = DATA_W + CNT_W;

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] droop_gain_r, shift_gain_r;
  logic [LIM_W-1:0]         droop_limit_r;

  opcode_t                  in_op;
  logic [IDX_W-1:0]         in_idx;
  logic signed [DATA_W-1:0] in_cur, in_vref;
  logic                     in_fire;

  opcode_t                  op_r;
  logic signed [DATA_W-1:0] cur_r, vref_r;
  logic signed [DATA_W-1:0] avg_r, corr_r, dterm_r;
  logic [CNT_W-1:0]         last_cnt_r, cnt_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic [SLOT_W-1:0]        walk_r;

  logic                     out_tvalid_r;
  logic [OUT_W-1:0]         out_tdata_r;

  slot_ctl_t                slot_ctl;
  logic [DATA_W-1:0]        rd_data;
  logic                     rd_live;

  logic signed [DATA_W-1:0]   mul_a, mul_b;
  logic signed [2*DATA_W-1:0] prod, prod_sh;
  logic signed [DATA_W-1:0]   term;

  logic                     div_start;
  div_stat_t                div_stat;
  logic signed [DATA_W-1:0] quot;

  logic signed [DATA_W+1:0] corr_wide;
  logic signed [DATA_W-1:0] corr_sat;

  logic accum, walk_last, out_load, out_free;

  assign in_op   = opcode_t'(in_tdata[1:0]);
  assign in_idx  = in_tdata[6:2];
  assign in_cur  = in_tdata[38:7];
  assign in_vref = in_tdata[70:39];
  assign in_fire = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign walk_last = walk_r == SLOT_W'(SLOTS - 1);

  dcs_slots #(.SLOTS(SLOTS), .SLOT_W(SLOT_W)) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (slot_ctl),
    .wr_addr (SLOT_W'(in_idx)),
    .wr_data (in_cur),
    .rd_addr (walk_r),
    .rd_data (rd_data),
    .rd_live (rd_live)
  );

  dcs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  dcs_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (cnt_r),
    .stat     (div_stat),
    .quotient (quot)
  );

  // Term: floor(product / 2^FRAC_BITS), clamped to +/- limit.
  assign prod_sh = prod >>> FRAC_BITS;
  always_comb begin
    if (prod_sh > $signed({{(DATA_W+1){1'b0}}, droop_limit_r})) begin
      term = $signed({1'b0, droop_limit_r});
    end else if (prod_sh < -$signed({{(DATA_W+1){1'b0}}, droop_limit_r})) begin
      term = -$signed({1'b0, droop_limit_r});
    end else begin
      term = prod_sh[DATA_W-1:0];
    end
  end

  assign corr_wide = {{2{vref_r[DATA_W-1]}}, vref_r}
                   - {{2{dterm_r[DATA_W-1]}}, dterm_r}
                   + {{2{term[DATA_W-1]}}, term};
  always_comb begin
    if (corr_wide > $signed({3'b000, {(DATA_W-1){1'b1}}})) begin
      corr_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (corr_wide < $signed({3'b111, {(DATA_W-1){1'b0}}})) begin
      corr_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      corr_sat = corr_wide[DATA_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_TICK: state_nxt = S_WALK;
            OP_RUN:  state_nxt = S_MUL_D;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_WALK:      state_nxt = walk_last ? S_WALK_END : S_WALK;
      S_WALK_END:  state_nxt = S_DIV_START;
      S_DIV_START: state_nxt = (cnt_r == '0) ? S_OUT : S_DIV_WAIT;
      S_DIV_WAIT:  state_nxt = div_stat.done ? S_OUT : S_DIV_WAIT;
      S_MUL_D:     state_nxt = S_MUL_S;
      S_MUL_S:     state_nxt = S_CORR;
      S_CORR:      state_nxt = S_OUT;
      S_OUT:       state_nxt = out_free ? S_IDLE : S_OUT;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = 1'b0;
    slot_ctl.wr_en   = 1'b0;
    slot_ctl.walk_en = 1'b0;
    accum            = 1'b0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    mul_a            = droop_gain_r;
    mul_b            = cur_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready      = 1'b1;
        slot_ctl.wr_en = in_fire && (in_op == OP_REPORT)
                         && ({1'b0, in_idx} < (IDX_W + 1)'(SLOTS));
      end
      S_WALK: begin
        slot_ctl.walk_en = 1'b1;
        accum            = rd_live;
      end
      S_WALK_END:  accum = rd_live;
      S_DIV_START: div_start = cnt_r != '0;
      S_MUL_S: begin
        mul_a = shift_gain_r;
        mul_b = avg_r;
      end
      S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      droop_gain_r  <= '0;
      shift_gain_r  <= '0;
      droop_limit_r <= '0;
      avg_r         <= '0;
      last_cnt_r    <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DROOP_GAIN:  droop_gain_r  <= cfg_wdata;
          REG_SHIFT_GAIN:  shift_gain_r  <= cfg_wdata;
          REG_DROOP_LIMIT: droop_limit_r <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DIV_START) begin
        last_cnt_r <= cnt_r;
        if (cnt_r == '0) begin
          avg_r <= '0;
        end
      end
      if ((state_r == S_DIV_WAIT) && div_stat.done) begin
        avg_r <= quot;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_op;
      cur_r  <= in_cur;
      vref_r <= in_vref;
      corr_r <= '0;
      acc_r  <= '0;
      cnt_r  <= '0;
      walk_r <= '0;
    end
    if (slot_ctl.walk_en) begin
      walk_r <= walk_r + SLOT_W'(1);
    end
    if (accum) begin
      acc_r <= acc_r + {{CNT_W{rd_data[DATA_W-1]}}, rd_data};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (state_r == S_MUL_S) begin
      dterm_r <= term;
    end
    if ((state_r == S_CORR) && (op_r == OP_RUN)) begin
      corr_r <= corr_sat;
    end
    if (out_load) begin
      out_tdata_r <= {(OUT_W - 2*DATA_W - LIVE_W)'(0), LIVE_W'(last_cnt_r), avg_r, corr_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTH
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    slot_ctl.wr_en |-> (state_r == S_IDLE))
    else $error("slot write outside idle");
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("divider busy while accepting");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_START) |-> (cnt_r <= CNT_W'(SLOTS)))
    else $error("live count above slot count");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV_WAIT) && div_stat.done) |=> (state_r == S_OUT))
    else $error("divider result not forwarded");
`endif

endmodule

/* tb/droop_current_sharing_test.sv */
module droop_current_sharing_test;
  import dcs_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] corrected;
    logic signed [DATA_W-1:0] average;
    logic [LIVE_W-1:0]        live;
  } word_result_t;

  localparam longint V_MAX = 64'sd2147483647;
  localparam longint V_MIN = -64'sd2147483648;
  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0100_0000;
  localparam logic [30:0] L_MAX = 31'h7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // predictor state
  logic signed [DATA_W-1:0] slot_current [NODE_COUNT_DEF] = '{default: '0};
  logic [AGE_W-1:0] slot_age [NODE_COUNT_DEF] = '{default: '0};
  logic signed [DATA_W-1:0] mean_current = '0;
  logic [LIVE_W-1:0] live_count = '0;
  logic signed [DATA_W-1:0] droop_gain = '0;
  logic signed [DATA_W-1:0] shift_gain = '0;
  logic [LIM_W-1:0] term_limit = '0;

  logic [IN_W-1:0] pending_words [$];
  word_result_t expected_results [$];

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_input = 1'b0;
  int fail_count = 0;

  droop_current_sharing #(
    .NODE_COUNT(NODE_COUNT_DEF),
    .FRAC_BITS (FRAC_BITS_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_term(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic word_result_t predict_word(logic [IN_W-1:0] w);
    opcode_t op;
    logic [IDX_W-1:0] idx;
    logic signed [DATA_W-1:0] cur;
    logic signed [DATA_W-1:0] vref;
    longint sum;
    longint lim;
    longint dterm;
    longint sterm;
    longint corr;
    int live;
    word_result_t r;
    op   = opcode_t'(w[1:0]);
    idx  = w[6:2];
    cur  = w[38:7];
    vref = w[70:39];
    corr = 0;
    case (op)
      OP_REPORT: begin
        if (idx < NODE_COUNT_DEF && idx < SLOT_LIMIT) begin
          slot_current[idx] = cur;
          slot_age[idx] = NODE_LIFE;
        end
      end
      OP_TICK: begin
        sum = 0;
        live = 0;
        for (int i = 0; i < NODE_COUNT_DEF; i++) begin
          if (slot_age[i] != 0) begin
            sum += longint'(slot_current[i]);
            live++;
            slot_age[i] = slot_age[i] - 1'b1;
          end
        end
        mean_current = (live > 0) ? DATA_W'(sum / live) : '0;
        live_count = LIVE_W'(live);
      end
      OP_RUN: begin
        lim = longint'({1'b0, term_limit});
        dterm = clamp_term((longint'(droop_gain) * longint'(cur)) >>> FRAC_BITS_DEF, lim);
        sterm = clamp_term((longint'(shift_gain) * longint'(mean_current)) >>> FRAC_BITS_DEF,
                           lim);
        corr = longint'(vref) - dterm + sterm;
        if (corr > V_MAX) corr = V_MAX;
        else if (corr < V_MIN) corr = V_MIN;
      end
      default: ;
    endcase
    r.corrected = DATA_W'(corr);
    r.average = mean_current;
    r.live = live_count;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_word(in_tdata));
      if (in_tvalid && !in_tready) begin
        // hold the current word
      end else if (pending_words.size() != 0 && !hold_input &&
                   $urandom_range(0, 99) >= send_idle) begin
        in_tdata <= pending_words.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic flag_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // monitor
  always @(posedge clk) begin
    word_result_t got;
    word_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.corrected = out_tdata[31:0];
        got.average = out_tdata[63:32];
        got.live = out_tdata[69:64];
        if (expected_results.size() == 0) begin
          flag_failure($sformatf("unexpected word: corrected %0d average %0d live %0d",
                                 got.corrected, got.average, got.live));
        end else begin
          want = expected_results.pop_front();
          if (got.corrected !== want.corrected || got.average !== want.average ||
              got.live !== want.live)
            flag_failure($sformatf(
              "mismatch: corrected exp %0d got %0d, average exp %0d got %0d, live exp %0d got %0d",
              want.corrected, got.corrected, want.average, got.average, want.live, got.live));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic add_word(opcode_t op, int unsigned idx, logic [31:0] cur,
                          logic [31:0] vref);
    pending_words.push_back({1'b0, vref, cur, IDX_W'(idx), op});
  endtask

  function automatic logic [31:0] rand_current();
    int v;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        v = int'($urandom_range(0, 2097152)) - 1048576;
        return v;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return W_MIN;
          1: return W_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        v = int'($urandom_range(0, 134217728)) - 67108864;
        return v;
      end
    endcase
  endfunction

  task automatic gen_random(int n);
    int kind;
    while (pending_words.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        repeat ($urandom_range(1, 6))
          add_word(OP_REPORT, $urandom_range(0, 31), rand_current(), $urandom);
        add_word(OP_TICK, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 4))
          add_word(OP_RUN, $urandom, rand_current(), rand_current());
      end else if (kind < 58) begin
        for (int i = 0; i < NODE_COUNT_DEF; i++)
          add_word(OP_REPORT, i, rand_current(), $urandom);
        add_word(OP_TICK, $urandom, $urandom, $urandom);
        add_word(OP_RUN, $urandom, rand_current(), rand_current());
      end else if (kind < 78) begin
        add_word(OP_RUN, $urandom, rand_current(), rand_current());
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4)) add_word(OP_TICK, $urandom, $urandom, $urandom);
      end else begin
        add_word(opcode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    case (r)
      REG_DROOP_GAIN:  droop_gain = v;
      REG_SHIFT_GAIN:  shift_gain = v;
      REG_DROOP_LIMIT: term_limit = v[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] dg, logic [31:0] sg, logic [30:0] lim);
    write_reg(REG_DROOP_GAIN, dg);
    write_reg(REG_SHIFT_GAIN, sg);
    write_reg(REG_DROOP_LIMIT, {1'b0, lim});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int sidle, int ridle, int n, bit pause);
    @(negedge clk);
    send_idle = sidle;
    recv_idle = ridle;
    gen_random(n);
    if (pause) begin
      while (pending_words.size() > n / 2) @(negedge clk);
      hold_input = 1'b1;
      while (in_tvalid || expected_results.size() != 0) @(negedge clk);
      hold_input = 1'b0;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 30;
    recv_idle = 70;
    set_config(W_MIN, W_MAX, L_MAX);
    @(negedge clk);
    add_word(OP_TICK, 0, '0, '0);
    add_word(OP_RUN, 0, 32'd1, W_MIN);
    add_word(OP_RUN, 0, W_MAX, W_MIN);
    add_word(OP_NOP, 31, W_MAX, W_MIN);
    add_word(OP_REPORT, 0, W_MAX, '0);
    add_word(OP_REPORT, 31, W_MAX, '0);
    add_word(OP_TICK, 0, '0, '0);
    add_word(OP_RUN, 0, W_MAX, W_MAX);
    add_word(OP_RUN, 0, '0, '0);
    add_word(OP_REPORT, 0, -32'sd3, '0);
    add_word(OP_REPORT, 31, '0, '0);
    add_word(OP_TICK, 0, '0, '0);
    add_word(OP_RUN, 0, W_MIN, W_MIN);
    add_word(OP_RUN, 0, '1, '1);
    add_word(OP_REPORT, 1, W_MIN, W_MAX);
    add_word(OP_TICK, 31, '1, '1);
    add_word(OP_NOP, 0, '0, '0);
    repeat (3) add_word(OP_TICK, $urandom, $urandom, $urandom);
    add_word(OP_RUN, $urandom, $urandom, $urandom);
    add_word(OP_NOP, $urandom, $urandom, $urandom);
    drain();

    set_config(Q_ONE, Q_ONE >> 1, 31'h1000_0000);
    run_phase(30, 70, 330, 1'b1);
    write_reg(REG_NONE, $urandom);
    set_config('0, '0, '0);
    run_phase(30, 70, 330, 1'b0);
    set_config(W_MIN, W_MIN, L_MAX);
    run_phase(70, 30, 330, 1'b0);
    set_config($urandom, $urandom, LIM_W'($urandom));
    run_phase(70, 30, 330, 1'b0);
    set_config(W_MAX, W_MAX, LIM_W'($urandom_range(0, 67108864)));
    run_phase(0, 0, 330, 1'b0);
    set_config($urandom, $urandom, LIM_W'($urandom));
    run_phase(0, 0, 330, 1'b0);

    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* droop_current_sharing.f */
src/dcs_pkg.sv
src/dcs_slots.sv
src/dcs_mul.sv
src/dcs_div.sv
src/droop_current_sharing.sv
tb/droop_current_sharing_test.sv
